// ----- rtl/core/nc_pkg.sv -----
package nc_pkg;

    localparam int WINDOW      = 12;
    localparam int SAMPLE_BITS = 16;

    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    localparam int Q_BITS = 16;
    localparam int WT_W   = Q_BITS + 1;

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int WSUM_W = WT_W + $clog2(WINDOW);
    localparam int ACC_W  = SAMPLE_BITS + WT_W + $clog2(WINDOW);

    localparam int DIVN_W = (ACC_W > SAMPLE_BITS + Q_BITS) ? ACC_W : SAMPLE_BITS + Q_BITS;
    localparam int DIVD_W = (WSUM_W > SAMPLE_BITS) ? WSUM_W : SAMPLE_BITS;
    localparam int DCNT_W = $clog2(DIVN_W + 1);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [WT_W-1:0]        t_wt;
    typedef logic [WSUM_W-1:0]      t_wsum;
    typedef logic [ACC_W-1:0]       t_acc;
    typedef logic [DIVN_W-1:0]      t_dividend;
    typedef logic [DIVD_W-1:0]      t_divisor;

    localparam t_wt Q_ONE  = t_wt'(1) << Q_BITS;
    localparam t_wt Q_HALF = t_wt'(1) << (Q_BITS - 1);

    typedef struct packed {
        logic      start;
        t_dividend dividend;
        t_divisor  divisor;
    } t_div_req;

    typedef struct packed {
        logic      busy;
        logic      done;
        t_dividend quotient;
    } t_div_rsp;

endpackage

// ----- rtl/core/nc_if.sv -----
interface nc_in_if;
    import nc_pkg::*;
    logic            valid;
    logic            ready;
    logic [IN_W-1:0] concentration;
    modport source(output valid, output concentration, input ready);
    modport sink(input valid, input concentration, output ready);
endinterface

interface nc_out_if;
    import nc_pkg::*;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] nowcast;
    logic             valid_res;
    modport source(output valid, output nowcast, output valid_res, input ready);
    modport sink(input valid, input nowcast, input valid_res, output ready);
endinterface

// ----- rtl/core/nc_ram.sv -----
module nc_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [DATA_W-1:0]                           i_wdata,
    output logic [DATA_W-1:0]                           o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/nc_div.sv -----
module nc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nc_pkg::t_div_req  i_req,
    output nc_pkg::t_div_rsp  o_rsp
);
    import nc_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [DCNT_W-1:0]   r_cnt;
    t_divisor            r_rem;
    t_divisor            r_div;
    t_dividend           r_quo;

    logic [DIVD_W:0]     rem_sh;
    logic                take;
    logic [DIVD_W:0]     rem_sub;

    // restoring division, one quotient bit per cycle; dividend shifts out as quotient shifts in
    assign rem_sh  = {r_rem, r_quo[DIVN_W-1]};
    assign take    = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIVN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= take ? rem_sub[DIVD_W-1:0] : rem_sh[DIVD_W-1:0];
            r_quo <= {r_quo[DIVN_W-2:0], take};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// ----- rtl/core/pm25_nowcast_average.sv -----
// NowCast average over a ring of WINDOW samples held in a single-port RAM.
// Window not yet full: no averaging pass; the input goes straight to the done state.
// Full window: the result is set by two RAM sweeps (min/max, then weighted sum) and by
// two bit-serial divisions (the first is skipped when the window is all zero).
// One input word is worked on at a time; the next input is taken while a result waits.
// Synchronous active-low reset clears control state; RAM contents need no clearing.
module pm25_nowcast_average (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nc_in_if.sink     i_in,
    nc_out_if.source  o_out
);
    import nc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MM   = 3'd1;
    localparam logic [2:0] S_WF   = 3'd2;
    localparam logic [2:0] S_DIV1 = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_QS   = 3'd5;
    localparam logic [2:0] S_DIV2 = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state;
    t_idx       r_slot;
    t_cnt       r_cnt;
    t_idx       r_ptr;
    t_cnt       r_step;
    t_sample    r_lo;
    t_sample    r_hi;
    t_wt        r_w;
    t_wt        r_wt;
    t_wsum      r_wsum;
    t_acc       r_acc;
    logic [OUT_W-1:0] r_res;
    logic       r_res_vld;
    logic       r_out_valid;
    logic [OUT_W-1:0] r_out_nowcast;
    logic       r_out_vres;

    logic       in_acc;
    t_cnt       n_cnt;
    t_idx       n_slot;
    t_idx       n_ptr;
    logic       step_issue;
    logic       step_proc;
    logic       out_load;
    t_idx       ram_addr;
    t_sample    ram_rdata;
    t_sample    sample;
    t_div_req   div_req;
    t_div_rsp   div_rsp;
    logic [WT_W+SAMPLE_BITS-1:0] prod_acc;
    logic [2*WT_W-1:0]           prod_wt;

    assign sample     = t_sample'(i_in.concentration);
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    assign n_cnt  = (r_cnt < CNT_W'(WINDOW)) ? r_cnt + 1'b1 : r_cnt;
    assign n_slot = (r_slot == IDX_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
    assign n_ptr  = (r_ptr == '0) ? IDX_W'(WINDOW - 1) : r_ptr - 1'b1;

    assign step_issue = r_step < CNT_W'(WINDOW);
    assign step_proc  = r_step != '0;

    always_comb begin
        ram_addr = '0;
        case (r_state)
            S_IDLE:  ram_addr = r_slot;
            S_MM:    ram_addr = step_issue ? r_step[IDX_W-1:0] : '0;
            S_ACC:   ram_addr = r_ptr;
            default: ram_addr = '0;
        endcase
    end

    nc_ram #(
        .DATA_W(SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (in_acc),
        .i_addr (ram_addr),
        .i_wdata(sample),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = t_dividend'({r_lo, Q_BITS'(0)});
        div_req.divisor  = t_divisor'(r_hi);
        if (r_state == S_WF) begin
            div_req.start = (r_hi != '0);
        end else if (r_state == S_QS) begin
            div_req.start    = 1'b1;
            div_req.dividend = t_dividend'(r_acc);
            div_req.divisor  = t_divisor'(r_wsum);
        end
    end

    nc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign prod_acc = (WT_W + SAMPLE_BITS)'(r_wt) * (WT_W + SAMPLE_BITS)'(ram_rdata);
    assign prod_wt  = (2 * WT_W)'(r_wt) * (2 * WT_W)'(r_w);

    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_cnt       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_slot <= n_slot;
                        r_cnt  <= n_cnt;
                        r_step <= '0;
                        r_state <= (n_cnt == CNT_W'(WINDOW)) ? S_MM : S_DONE;
                    end
                end
                S_MM: begin
                    if (step_issue) begin
                        r_step <= r_step + 1'b1;
                    end else begin
                        r_state <= S_WF;
                    end
                end
                S_WF: begin
                    r_step  <= '0;
                    r_state <= (r_hi == '0) ? S_ACC : S_DIV1;
                end
                S_DIV1: begin
                    if (div_rsp.done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (step_issue) begin
                        r_step <= r_step + 1'b1;
                    end else begin
                        r_state <= S_QS;
                    end
                end
                S_QS: begin
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    if (div_rsp.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ptr     <= r_slot;
                r_res     <= '0;
                r_res_vld <= 1'b0;
            end
            S_MM: begin
                if (step_proc && step_issue == 1'b0 || step_proc) begin
                    if (r_step == CNT_W'(1)) begin
                        r_lo <= ram_rdata;
                        r_hi <= ram_rdata;
                    end else begin
                        if (ram_rdata < r_lo) r_lo <= ram_rdata;
                        if (ram_rdata > r_hi) r_hi <= ram_rdata;
                    end
                end
            end
            S_WF: begin
                r_w    <= Q_ONE;
                r_wt   <= Q_ONE;
                r_wsum <= '0;
                r_acc  <= '0;
            end
            S_DIV1: begin
                // w = min/max, raised to at least one half
                if (div_rsp.done) begin
                    r_w <= (div_rsp.quotient <= t_dividend'(Q_HALF)) ?
                           Q_HALF : div_rsp.quotient[WT_W-1:0];
                end
            end
            S_ACC: begin
                if (step_issue) begin
                    r_ptr <= n_ptr;
                end
                if (step_proc) begin
                    r_wsum <= r_wsum + t_wsum'(r_wt);
                    r_acc  <= r_acc + t_acc'(prod_acc);
                    r_wt   <= prod_wt[Q_BITS +: WT_W];
                end
            end
            S_DIV2: begin
                if (div_rsp.done) begin
                    r_res     <= div_rsp.quotient[OUT_W-1:0];
                    r_res_vld <= 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_nowcast <= r_res;
            r_out_vres    <= r_res_vld;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.nowcast   = r_out_nowcast;
    assign o_out.valid_res = r_out_vres;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(WINDOW))
        else $error("fill count beyond window");

    a_w_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_w >= Q_HALF && r_w <= Q_ONE))
        else $error("weight factor out of range");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.valid_res) |-> (o_out.nowcast == '0))
        else $error("invalid result word carries non-zero nowcast");

    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_out.ready) |=> (r_state == S_DONE))
        else $error("result dropped while output word stalled");
endmodule

// ----- tb/sv/nowcast_checker.sv -----
`timescale 1ns / 100ps

module nowcast_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    nc_in_if     i_in,
    nc_out_if    i_out,
    output int   o_fail_count,
    output int   o_pending
);
    import nc_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] nowcast;
        logic             valid_res;
    } t_nowcast_word;

    t_sample       window_samples [WINDOW];
    int            next_slot;
    int            held_count;
    int            mismatches;
    t_nowcast_word awaited_q [$];
    t_nowcast_word oldest;

    // Stores a sample in the ring; returns the owed average (zero word if not full)
    function automatic t_nowcast_word absorb_sample(input t_sample sample);
        logic [63:0]   lo;
        logic [63:0]   hi;
        logic [63:0]   w;
        logic [63:0]   wt;
        logic [63:0]   wsum;
        logic [63:0]   acc;
        int            newest;
        int            slot;
        t_nowcast_word word;
        newest = next_slot;
        window_samples[newest] = sample;
        next_slot = (newest == WINDOW - 1) ? 0 : newest + 1;
        if (held_count < WINDOW) begin
            held_count++;
        end
        word = '0;
        if (held_count < WINDOW) begin
            return word;
        end
        lo = 64'(window_samples[0]);
        hi = 64'(window_samples[0]);
        for (int k = 1; k < WINDOW; k++) begin
            if (64'(window_samples[k]) < lo) begin
                lo = 64'(window_samples[k]);
            end
            if (64'(window_samples[k]) > hi) begin
                hi = 64'(window_samples[k]);
            end
        end
        // all-zero window: unit weight, avoids dividing by zero
        if (hi == 0) begin
            w = 64'(Q_ONE);
        end else begin
            w = (lo << Q_BITS) / hi;
            if (w <= 64'(Q_HALF)) begin
                w = 64'(Q_HALF);
            end
        end
        wt   = 64'(Q_ONE);
        wsum = '0;
        acc  = '0;
        for (int age = 0; age < WINDOW; age++) begin
            slot = (newest + WINDOW - age) % WINDOW;
            wsum += wt;
            acc  += wt * 64'(window_samples[slot]);
            wt    = (wt * w) >> Q_BITS;
        end
        word.nowcast   = OUT_W'(acc / wsum);
        word.valid_res = 1'b1;
        return word;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (window_samples[k]) window_samples[k] = '0;
            next_slot  = 0;
            held_count = 0;
            awaited_q.delete();
        end else begin
            // result word first: it can never belong to the word taken on this edge
            if (i_out.valid && i_out.ready) begin
                if (awaited_q.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, %s%0d valid_res=%0b",
                             $time, "got nowcast=", i_out.nowcast, i_out.valid_res);
                    mismatches++;
                end else begin
                    oldest = awaited_q.pop_front();
                    if (i_out.nowcast !== oldest.nowcast) begin
                        $display("%0t: nowcast expected %0d, got %0d",
                                 $time, oldest.nowcast, i_out.nowcast);
                        mismatches++;
                    end
                    if (i_out.valid_res !== oldest.valid_res) begin
                        $display("%0t: valid_res expected %0b, got %0b",
                                 $time, oldest.valid_res, i_out.valid_res);
                        mismatches++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                awaited_q.push_back(absorb_sample(t_sample'(i_in.concentration)));
            end
        end
        o_pending    <= awaited_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- tb/sv/pm25_nowcast_average_tb.sv -----
`timescale 1ns / 100ps

module pm25_nowcast_average_tb;
    import nc_pkg::*;

    localparam int RANDOM_WORDS = 450;
    localparam int RUN_LENGTH   = 24;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 150;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_AT      = 150;
    localparam int PAUSE_AT     = 300;

    typedef enum int {
        MIX_FULL,
        MIX_CLUSTER,
        MIX_LOW,
        MIX_ZERO_HEAVY
    } t_sample_mix;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;

    nc_in_if  in_ch ();
    nc_out_if out_ch ();

    pm25_nowcast_average dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    nowcast_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // valid is left high after a word is taken so back-to-back words need no re-raise
    task automatic send_word(input logic [IN_W-1:0] sample, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.concentration <= sample;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        t_sample_mix mix;
        int          base;
        int          spread;
        int          sample_v;
        int          pick;
        logic        burst;
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.concentration = '0;
        mix                 = MIX_FULL;
        base                = 1;
        spread              = 0;
        burst               = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all-zero window, then zero minimum, then a flat full-scale window,
        // then a single tiny sample against full scale
        for (int k = 0; k < WINDOW; k++) send_word('0, $urandom_range(0, 19));
        for (int k = 0; k < WINDOW; k++) send_word('1, $urandom_range(0, 19));
        send_word(IN_W'(1), $urandom_range(0, 19));

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % RUN_LENGTH == 0) begin
                pick = $urandom_range(0, 5);
                case (pick)
                    0, 1, 2: mix = MIX_CLUSTER;
                    3:       mix = MIX_FULL;
                    4:       mix = MIX_LOW;
                    default: mix = MIX_ZERO_HEAVY;
                endcase
                base   = $urandom_range(1, 65535);
                spread = $urandom_range(0, 1) ? (base >> 2) : (base >> 6);
                burst  = ($urandom_range(0, 3) == 0);
            end
            case (mix)
                MIX_CLUSTER: begin
                    sample_v = base - spread + $urandom_range(0, 2 * spread);
                    if (sample_v > 65535) begin
                        sample_v = 65535;
                    end
                end
                MIX_LOW:        sample_v = $urandom_range(0, 15);
                MIX_ZERO_HEAVY: sample_v = ($urandom_range(0, 3) == 0) ? 0
                                                                       : $urandom_range(0, 65535);
                default:        sample_v = $urandom_range(0, 65535);
            endcase
            if (n == PAUSE_AT) begin
                wait_drained();
            end
            send_word(IN_W'(sample_v), burst ? 0 : $urandom_range(0, 19));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("pm25_nowcast_average regression: pass");
        end else begin
            $display("pm25_nowcast_average regression: fail");
        end
        $finish;
    end

    initial begin
        int   stall;
        int   taken;
        logic calm;
        out_ch.ready = 1'b0;
        taken        = 0;
        calm         = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            // long back-pressure: input side fills up and stalls
            if (taken == HOLD_AT) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (taken % 32 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("pm25_nowcast_average regression: fail");
        $finish;
    end

endmodule
